[rtl/prat_pkg.sv]
`timescale 1ns / 1ps
package prat_pkg;
  localparam int ENTRIES    = 64;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SUM_W      = 8 + IDX_W;
  localparam int TOTAL_W    = 14;

  localparam logic [1:0] FUNC_ALLOC     = 2'd0;
  localparam logic [1:0] FUNC_FREE      = 2'd1;
  localparam logic [1:0] FUNC_TRANSLATE = 2'd2;

  localparam logic [1:0] KIND_FREE  = 2'd0;
  localparam logic [1:0] KIND_HEAP  = 2'd1;
  localparam logic [1:0] KIND_STACK = 2'd2;

  localparam logic PAGE_HEAP  = 1'b0;
  localparam logic PAGE_STACK = 1'b1;

  localparam logic [1:0] CFG_HEAP_TOP  = 2'd0;
  localparam logic [1:0] CFG_STACK_TOP = 2'd1;
  localparam logic [1:0] CFG_REAL_BASE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [7:0]  pages;
    logic [15:0] owner;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_run;
    logic scan_finish;
    logic total_add;
    logic append_write;
    logic res_fail;
    logic res_ident;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       kind;
    logic       count_zero;
    logic       below_base;
    logic       table_full;
    logic       scan_hit;
    logic       scan_end;
  } stat_t;
endpackage

[rtl/prat_ram.sv]
`timescale 1ns / 1ps
module prat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/prat_datapath.sv]
`timescale 1ns / 1ps
module prat_datapath import prat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic [1:0]  func,
  input  logic        page_kind,
  input  logic [7:0]  page_count,
  input  logic [31:0] address,
  input  logic [15:0] owner_id,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic [31:0] result_address,
  output logic        status
);
  logic [31:0] heap_top, stack_top, real_base;
  logic [1:0]  req_func;
  logic        req_kind;
  logic [7:0]  req_count;
  logic [31:0] req_addr;
  logic [15:0] req_owner;
  logic [CNT_W-1:0]   used, rd_idx;
  logic [IDX_W-1:0]   chk_idx;
  logic               chk_vld;
  logic               any_hit;
  logic [SUM_W-1:0]   sum;
  logic [TOTAL_W-1:0] total, total_next;
  entry_t rd, wdata;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic reuse_hit, heap_hit, stack_hit, free_hit;
  logic [31:0] app_addr;

  prat_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(rd_idx[IDX_W-1:0]), .rdata(rd)
  );

  always_comb begin
    reuse_hit = req_func == FUNC_ALLOC && req_kind == PAGE_HEAP &&
                rd.kind == KIND_FREE && req_count <= rd.pages;
    heap_hit  = req_func == FUNC_TRANSLATE && rd.kind == KIND_HEAP && rd.addr == req_addr;
    stack_hit = req_func == FUNC_TRANSLATE && rd.kind == KIND_STACK &&
                rd.addr == req_addr && rd.owner == req_owner;
    free_hit  = req_func == FUNC_FREE && rd.addr == req_addr;
    total_next = total + TOTAL_W'(req_count);
    app_addr = (req_kind == PAGE_HEAP) ? heap_top - (32'(total) << PAGE_SHIFT)
                                       : stack_top - (32'(req_count) << PAGE_SHIFT);
    st.func       = req_func;
    st.kind       = req_kind;
    st.count_zero = req_count == 8'd0;
    st.below_base = req_addr < real_base;
    st.table_full = used == CNT_W'(ENTRIES);
    st.scan_hit   = chk_vld && (reuse_hit || heap_hit || stack_hit);
    st.scan_end   = !chk_vld && rd_idx == used;
    we    = 1'b0;
    waddr = chk_idx;
    wdata = rd;
    if (cmd.scan_run && chk_vld && reuse_hit) begin
      we         = 1'b1;
      wdata.kind = KIND_HEAP;
      wdata.owner = req_owner;
    end else if (cmd.scan_run && chk_vld && free_hit) begin
      we         = 1'b1;
      wdata.kind = KIND_FREE;
    end else if (cmd.append_write) begin
      we          = 1'b1;
      waddr       = used[IDX_W-1:0];
      wdata.kind  = (req_kind == PAGE_HEAP) ? KIND_HEAP : KIND_STACK;
      wdata.addr  = app_addr;
      wdata.pages = req_count;
      wdata.owner = req_owner;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_top  <= '0;
      stack_top <= '0;
      real_base <= '0;
      used      <= '0;
      total     <= '0;
      chk_vld   <= 1'b0;
      rd_idx    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAP_TOP:  heap_top  <= cfg_data;
          CFG_STACK_TOP: stack_top <= cfg_data;
          CFG_REAL_BASE: real_base <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.scan_init) begin
        rd_idx  <= '0;
        chk_vld <= 1'b0;
      end else if (cmd.scan_run) begin
        chk_idx <= rd_idx[IDX_W-1:0];
        if (rd_idx != used) begin
          rd_idx  <= rd_idx + 1'b1;
          chk_vld <= 1'b1;
        end else begin
          chk_vld <= 1'b0;
        end
      end
      if (cmd.total_add) begin
        total <= total_next;
      end
      if (cmd.append_write) begin
        used <= used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func  <= func;
      req_kind  <= page_kind;
      req_count <= page_count;
      req_addr  <= address;
      req_owner <= owner_id;
    end
    if (cmd.scan_init) begin
      sum     <= '0;
      any_hit <= 1'b0;
    end else if (cmd.scan_run && chk_vld) begin
      sum <= sum + SUM_W'(rd.pages);
      if (free_hit) begin
        any_hit <= 1'b1;
      end
    end
    if (cmd.res_fail) begin
      result_address <= '0;
      status         <= 1'b1;
    end else if (cmd.res_ident) begin
      result_address <= req_addr;
      status         <= 1'b0;
    end else if (cmd.scan_finish) begin
      result_address <= '0;
      status         <= (req_func == FUNC_FREE) ? !any_hit : 1'b1;
    end else if (cmd.append_write) begin
      result_address <= (req_kind == PAGE_HEAP) ? app_addr : stack_top;
      status         <= 1'b0;
    end else if (cmd.scan_run && chk_vld) begin
      if (reuse_hit) begin
        result_address <= rd.addr;
        status         <= 1'b0;
      end else if (heap_hit) begin
        result_address <= heap_top - rd.addr - (32'(rd.pages) << PAGE_SHIFT) + real_base;
        status         <= 1'b0;
      end else if (stack_hit) begin
        result_address <= real_base + (32'(sum) << PAGE_SHIFT);
        status         <= 1'b0;
      end
    end
  end
endmodule

[rtl/prat_ctrl.sv]
`timescale 1ns / 1ps
module prat_ctrl import prat_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t st,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_SCAN, S_APPEND, S_WRITE, S_REPLY
  } state_t;
  state_t state;

  always_comb begin
    cmd = '0;
    cmd.load = start && !busy;
    case (state)
      S_DECIDE: begin
        if (st.func == FUNC_ALLOC) begin
          if (st.count_zero) begin
            cmd.res_fail = 1'b1;
          end else if (st.kind == PAGE_HEAP) begin
            cmd.scan_init = 1'b1;
          end
        end else if (st.func == FUNC_TRANSLATE && st.below_base) begin
          cmd.res_ident = 1'b1;
        end else if (st.func == FUNC_FREE || st.func == FUNC_TRANSLATE) begin
          cmd.scan_init = 1'b1;
        end else begin
          cmd.res_fail = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_run    = 1'b1;
        cmd.scan_finish = !st.scan_hit && st.scan_end;
      end
      S_APPEND: begin
        cmd.res_fail  = st.table_full;
        cmd.total_add = !st.table_full && st.kind == PAGE_HEAP;
      end
      S_WRITE: cmd.append_write = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (cmd.scan_init) begin
            state <= S_SCAN;
          end else if (cmd.res_fail || cmd.res_ident) begin
            done  <= 1'b1;
            state <= S_REPLY;
          end else begin
            state <= S_APPEND;
          end
        end
        S_SCAN: begin
          if (st.scan_hit) begin
            done  <= 1'b1;
            state <= S_REPLY;
          end else if (st.scan_end) begin
            if (st.func == FUNC_ALLOC) begin
              state <= S_APPEND;
            end else begin
              done  <= 1'b1;
              state <= S_REPLY;
            end
          end
        end
        S_APPEND: begin
          if (st.table_full) begin
            done  <= 1'b1;
            state <= S_REPLY;
          end else begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          done  <= 1'b1;
          state <= S_REPLY;
        end
        S_REPLY: begin
          done  <= 1'b0;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy held after result beat");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
  assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result beat while idle");
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.scan_init, cmd.total_add, cmd.append_write, cmd.res_fail}))
    else $error("conflicting datapath commands");
endmodule

[rtl/page_run_allocator_table_unit.sv]
`timescale 1ns / 1ps
// Page run table: allocate, free and translate requests. One request at a time;
// a request is taken when start is high and busy low. A request that walks the
// table reads one entry per cycle from a single RAM read port. A free walks all
// used entries, while a translate or heap allocate stops at its first hit; the
// table holds at most 64 entries. The result beat is done high for one cycle and
// cannot be stalled, so the receiver must take it then. Config writes are always
// ready and should only be made while busy is low.
module page_run_allocator_table_unit import prat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic        page_kind,
  input  logic [7:0]  page_count,
  input  logic [31:0] address,
  input  logic [15:0] owner_id,
  output logic        done,
  output logic [31:0] result_address,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  prat_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .st(st), .cmd(cmd), .busy(busy), .done(done)
  );

  prat_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .func(func), .page_kind(page_kind), .page_count(page_count),
    .address(address), .owner_id(owner_id),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_address(result_address), .status(status)
  );
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import prat_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  func;
  logic        page_kind;
  logic [7:0]  page_count;
  logic [31:0] address;
  logic [15:0] owner_id;
  logic        done;
  logic [31:0] result_address;
  logic        status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  page_run_allocator_table_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .page_kind(page_kind), .page_count(page_count), .address(address),
    .owner_id(owner_id), .done(done), .result_address(result_address),
    .status(status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int LIMIT_CYCLES = 1000000;
  localparam logic [1:0] FUNC_BAD = 2'd3;

  typedef struct packed {
    logic [31:0] addr;
    logic        fail;
  } reply_t;

  // predictor state
  logic [31:0] heap_top_q, stack_top_q, real_base_q;
  logic [1:0]  tbl_kind [ENTRIES];
  logic [31:0] tbl_addr [ENTRIES];
  logic [7:0]  tbl_pages [ENTRIES];
  logic [15:0] tbl_owner [ENTRIES];
  int          tbl_used;
  logic [13:0] heap_total;

  reply_t      pending_replies[$];
  int          mismatches;
  int          cycles;
  logic        timed_out;
  logic [31:0] recent_addrs[$];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic reply_t predict_request(logic [1:0] f, logic k, logic [7:0] cnt,
                                              logic [31:0] a, logic [15:0] own);
    reply_t      r;
    logic [31:0] sum;
    logic        hit;
    r.addr = '0;
    r.fail = 1'b1;
    sum = '0;
    hit = 1'b0;
    if (f == FUNC_ALLOC) begin
      if (cnt == 0) return r;
      if (k == PAGE_HEAP) begin
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_kind[i] == KIND_FREE && cnt <= tbl_pages[i]) begin
            tbl_kind[i] = KIND_HEAP;
            tbl_owner[i] = own;
            r.addr = tbl_addr[i];
            r.fail = 1'b0;
            return r;
          end
        end
      end
      if (tbl_used >= ENTRIES) return r;
      tbl_pages[tbl_used] = cnt;
      tbl_owner[tbl_used] = own;
      if (k == PAGE_HEAP) begin
        heap_total = heap_total + 14'(cnt);
        tbl_kind[tbl_used] = KIND_HEAP;
        tbl_addr[tbl_used] = heap_top_q - 32'(PAGE_BYTES) * {18'd0, heap_total};
        r.addr = tbl_addr[tbl_used];
      end else begin
        tbl_kind[tbl_used] = KIND_STACK;
        tbl_addr[tbl_used] = stack_top_q - {24'd0, cnt} * 32'(PAGE_BYTES);
        r.addr = stack_top_q;
      end
      tbl_used++;
      r.fail = 1'b0;
    end else if (f == FUNC_FREE) begin
      for (int i = 0; i < tbl_used; i++) begin
        if (tbl_addr[i] == a) begin
          tbl_kind[i] = KIND_FREE;
          hit = 1'b1;
        end
      end
      r.fail = !hit;
    end else if (f == FUNC_TRANSLATE) begin
      if (a < real_base_q) begin
        r.addr = a;
        r.fail = 1'b0;
        return r;
      end
      for (int i = 0; i < tbl_used; i++) begin
        if (tbl_kind[i] == KIND_HEAP && tbl_addr[i] == a) begin
          r.addr = heap_top_q - (a + 32'(PAGE_BYTES) * {24'd0, tbl_pages[i]}) + real_base_q;
          r.fail = 1'b0;
          return r;
        end else if (tbl_kind[i] == KIND_STACK && tbl_addr[i] == a && tbl_owner[i] == own) begin
          r.addr = real_base_q + sum * 32'(PAGE_BYTES);
          r.fail = 1'b0;
          return r;
        end
        sum = sum + {24'd0, tbl_pages[i]};
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: addr %h status %b", result_address, status);
      end else begin
        exp_r = pending_replies.pop_front();
        if (exp_r.addr !== result_address || exp_r.fail !== status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr %h status %b, got addr %h status %b",
                     exp_r.addr, exp_r.fail, result_address, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES && !timed_out) begin
      timed_out = 1'b1;
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] f, logic k, logic [7:0] cnt, logic [31:0] a,
                              logic [15:0] own, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(8);
    repeat (gap) @(negedge clk);
    start = 1'b1;
    func = f;
    page_kind = k;
    page_count = cnt;
    address = a;
    owner_id = own;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_replies.push_back(predict_request(f, k, cnt, a, own));
    if (f == FUNC_ALLOC && pending_replies[$].fail == 1'b0) begin
      recent_addrs.push_back(pending_replies[$].addr);
      if (k == PAGE_STACK)
        recent_addrs.push_back(stack_top_q - {24'd0, cnt} * 32'(PAGE_BYTES));
      if (recent_addrs.size() > 32) void'(recent_addrs.pop_front());
    end
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] val);
    drain_results();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_HEAP_TOP:  heap_top_q = val;
      CFG_STACK_TOP: stack_top_q = val;
      default:       real_base_q = val;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_address();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6 && recent_addrs.size() != 0)
      return recent_addrs[$urandom_range(recent_addrs.size() - 1)];
    if (sel < 8) return $urandom_range(real_base_q > 0 ? real_base_q - 1 : 0);
    return $urandom;
  endfunction

  task automatic random_request();
    int          sel;
    logic [1:0]  f;
    logic [7:0]  cnt;
    sel = $urandom_range(99);
    if (sel < 45) f = FUNC_ALLOC;
    else if (sel < 65) f = FUNC_FREE;
    else if (sel < 97) f = FUNC_TRANSLATE;
    else f = FUNC_BAD;
    cnt = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
    if ($urandom_range(30) == 0) cnt = 8'd0;
    send_request(f, 1'($urandom), cnt, pick_address(),
                 ($urandom_range(1) == 0) ? 16'($urandom_range(3)) : 16'($urandom));
  endtask

  task automatic test_directed();
    write_register(CFG_HEAP_TOP, 32'h8000_0000);
    write_register(CFG_STACK_TOP, 32'hC000_0000);
    write_register(CFG_REAL_BASE, 32'h1000_0000);
    send_request(FUNC_ALLOC, PAGE_HEAP, 8'd0, '0, 16'd1);
    send_request(FUNC_ALLOC, PAGE_HEAP, 8'd4, '0, 16'd1);
    send_request(FUNC_ALLOC, PAGE_HEAP, 8'd255, '0, 16'hFFFF, 1);
    send_request(FUNC_ALLOC, PAGE_STACK, 8'd2, '0, 16'd7);
    send_request(FUNC_ALLOC, PAGE_STACK, 8'd255, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(FUNC_TRANSLATE, PAGE_HEAP, 8'd0, 32'h7FFF_C000, 16'd0);
    send_request(FUNC_TRANSLATE, PAGE_HEAP, 8'd0, 32'hBFFF_E000, 16'd7);
    send_request(FUNC_TRANSLATE, PAGE_HEAP, 8'd0, 32'hBFFF_E000, 16'd8);
    send_request(FUNC_TRANSLATE, PAGE_HEAP, 8'd0, 32'h0000_1234, 16'd0);
    send_request(FUNC_TRANSLATE, PAGE_HEAP, 8'd0, 32'hFFFF_FFFF, 16'd0);
    send_request(FUNC_FREE, PAGE_HEAP, 8'd0, 32'h7FFF_C000, 16'd0);
    send_request(FUNC_FREE, PAGE_HEAP, 8'd0, 32'h1234_5678, 16'd0);
    send_request(FUNC_ALLOC, PAGE_HEAP, 8'd3, '0, 16'd9);
    send_request(FUNC_FREE, PAGE_HEAP, 8'd0, 32'hBFFF_E000, 16'd0);
    send_request(FUNC_ALLOC, PAGE_HEAP, 8'd2, '0, 16'd5);
    send_request(FUNC_BAD, PAGE_STACK, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    drain_results();
  endtask

  task automatic test_full_table();
    write_register(CFG_REAL_BASE, 32'd0);
    while (tbl_used < ENTRIES) send_request(FUNC_ALLOC, 1'($urandom), 8'd1, '0, 16'd3);
    send_request(FUNC_ALLOC, PAGE_STACK, 8'd1, '0, 16'd3);
    send_request(FUNC_ALLOC, PAGE_HEAP, 8'd200, '0, 16'd3);
    for (int i = 0; i < 60; i++) random_request();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      write_register(CFG_HEAP_TOP, (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'd0 : $urandom);
      write_register(CFG_STACK_TOP, (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'd0 : $urandom);
      write_register(CFG_REAL_BASE, (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'd0 :
                     32'($urandom_range(32'h2000_0000)));
      for (int i = 0; i < 125; i++) begin
        if ($urandom_range(2) == 0) send_request(FUNC_ALLOC, 1'($urandom),
                                                 8'($urandom_range(1, 255)), '0, 16'($urandom), 1);
        else random_request();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_ALLOC;
    page_kind = PAGE_HEAP;
    page_count = '0;
    address = '0;
    owner_id = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HEAP_TOP;
    cfg_data = '0;
    heap_top_q = '0;
    stack_top_q = '0;
    real_base_q = '0;
    tbl_used = 0;
    heap_total = '0;
    mismatches = 0;
    cycles = 0;
    timed_out = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_full_table();
    test_random_phases();
    drain_results();
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
